// ===== rtl/core/cct_pkg.sv =====
package cct_pkg;

	// Width of the wrap count that forms the upper part of the extended count.
	localparam int WRAP_BITS = 32;

	// Default width of the sampled cycle counter.
	localparam int COUNTER_BITS_DEF = 32;

	// Clock frequency register and every divisor of the split.
	localparam int MHZ_W = 10;
	localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(168);
	localparam logic [MHZ_W-1:0] US_PER_MS = MHZ_W'(1000);

	// Port widths of the sample request and the result.
	localparam int SECONDS_W = 45;
	localparam int SUBSEC_W  = 10;
	localparam int TOTAL_W   = 64;
	localparam int DELTA_W   = 32;
	localparam int SAMPLE_W  = 32;

	// Control of one serial divider cell.
	typedef struct packed {
		logic clear;
		logic step;
	} cct_div_ctrl_t;

endpackage

// ===== rtl/core/cct_div_cell.sv =====
// One restoring division cell: takes a dividend bit per step, MSB first,
// and yields one quotient bit per step, leaving the remainder behind.
module cct_div_cell (
	input  logic                          clk,
	input  cct_pkg::cct_div_ctrl_t        ctrl,
	input  logic                          bit_in,
	input  logic [cct_pkg::MHZ_W-1:0]     divisor,
	output logic                          q_bit,
	output logic [cct_pkg::MHZ_W-1:0]     rem
);

	logic [cct_pkg::MHZ_W-1:0] rem_q;
	logic [cct_pkg::MHZ_W:0]   trial;
	logic [cct_pkg::MHZ_W:0]   diff;

	// Shift the next dividend bit in and try a subtraction.
	always_comb begin
		trial = {rem_q, bit_in};
		diff  = trial - {1'b0, divisor};
		q_bit = (trial >= {1'b0, divisor});
	end

	// The remainder stays below the divisor, so it always fits the narrow register.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			rem_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= q_bit ? diff[cct_pkg::MHZ_W-1:0] : trial[cct_pkg::MHZ_W-1:0];
		end
	end

	assign rem = rem_q;

endmodule

// ===== rtl/core/cct_wrap_track.sv =====
// Keeps the previous sample and the wrap count, and forms the extended count.
module cct_wrap_track #(
	parameter int COUNTER_BITS = cct_pkg::COUNTER_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic [cct_pkg::SAMPLE_W-1:0]           counter_sample,
	output logic [cct_pkg::WRAP_BITS+COUNTER_BITS-1:0] ext,
	output logic [cct_pkg::DELTA_W-1:0]            delta,
	output logic                                   wrapped
);

	logic [COUNTER_BITS-1:0]       sample;
	logic [COUNTER_BITS-1:0]       prev_q;
	logic [cct_pkg::WRAP_BITS-1:0] wrap_q;
	logic [cct_pkg::WRAP_BITS-1:0] wrap_next;
	logic [COUNTER_BITS-1:0]       diff;

	// A sample below the previous one counts as a wrap before extension.
	always_comb begin
		sample    = counter_sample[COUNTER_BITS-1:0];
		wrapped   = (sample < prev_q);
		wrap_next = wrap_q + cct_pkg::WRAP_BITS'(wrapped);
		diff      = sample - prev_q;
		delta     = cct_pkg::DELTA_W'(diff);
		ext       = {wrap_next, sample};
	end

	// Tracking state moves on with every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			wrap_q <= '0;
		end else if (accept) begin
			prev_q <= sample;
			wrap_q <= wrap_next;
		end
	end

endmodule

// ===== rtl/core/cycle_count_time_split.sv =====
// The block takes no new request until the finished result has moved into the output
// register, so output stalls hold up the input as well.
// The extended count leaves a shift register one bit a cycle through three chained
// divider cells (by the clock in MHz, by 1000, by 1000).
// Asynchronous active-low reset clears the previous sample, the wrap count and all
// handshakes, and sets the clock register to 168 MHz.
module cycle_count_time_split #(
	parameter int COUNTER_BITS = cct_pkg::COUNTER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cct_pkg::MHZ_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cct_pkg::SAMPLE_W-1:0]        counter_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cct_pkg::SECONDS_W-1:0]       seconds,
	output logic [cct_pkg::SUBSEC_W-1:0]        milliseconds,
	output logic [cct_pkg::SUBSEC_W-1:0]        microseconds,
	output logic [cct_pkg::TOTAL_W-1:0]         total_microseconds,
	output logic [cct_pkg::DELTA_W-1:0]         delta_cycles,
	output logic                                wrapped
);

	localparam int EXT_W = cct_pkg::WRAP_BITS + COUNTER_BITS;
	localparam int CNT_W = $clog2(EXT_W);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [cct_pkg::MHZ_W-1:0]   clock_mhz_q;
	logic [cct_pkg::MHZ_W-1:0]   div_q;
	logic [EXT_W-1:0]            dividend_q;
	logic [EXT_W-1:0]            total_q;
	logic [EXT_W-1:0]            secs_q;
	logic [cct_pkg::DELTA_W-1:0] delta_q;
	logic                        wrapped_q;

	logic                        out_valid_q;
	logic [cct_pkg::SECONDS_W-1:0] seconds_q;
	logic [cct_pkg::SUBSEC_W-1:0]  ms_q;
	logic [cct_pkg::SUBSEC_W-1:0]  us_q;
	logic [cct_pkg::TOTAL_W-1:0]   total_out_q;
	logic [cct_pkg::DELTA_W-1:0]   delta_out_q;
	logic                          wrapped_out_q;

	logic                        accept;
	logic                        load_out;
	logic                        last_step;
	logic [EXT_W-1:0]            ext;
	logic [cct_pkg::DELTA_W-1:0] delta;
	logic                        wrap_hit;
	cct_pkg::cct_div_ctrl_t      div_ctrl;
	logic                        q_mhz;
	logic                        q_ms;
	logic                        q_s;
	logic [cct_pkg::MHZ_W-1:0]   rem_mhz;
	logic [cct_pkg::MHZ_W-1:0]   rem_us;
	logic [cct_pkg::MHZ_W-1:0]   rem_ms;

	// Handshakes and sequencing strobes.
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		cfg_ready      = 1'b1;
		accept         = in_valid && in_ready;
		last_step      = (state_q == ST_RUN) && (cnt_q == CNT_W'(EXT_W - 1));
		load_out       = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		div_ctrl.clear = accept;
		div_ctrl.step  = (state_q == ST_RUN);
	end

	// Clock frequency register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_mhz_q <= cct_pkg::MHZ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			clock_mhz_q <= cfg_data;
		end
	end

	cct_wrap_track #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_wrap (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.counter_sample (counter_sample),
		.ext            (ext),
		.delta          (delta),
		.wrapped        (wrap_hit)
	);

	// Divide by the clock in MHz to get microseconds, then twice by 1000.
	cct_div_cell u_div_mhz (
		.clk     (clk),
		.ctrl    (div_ctrl),
		.bit_in  (dividend_q[EXT_W-1]),
		.divisor (div_q),
		.q_bit   (q_mhz),
		.rem     (rem_mhz)
	);

	cct_div_cell u_div_us (
		.clk     (clk),
		.ctrl    (div_ctrl),
		.bit_in  (q_mhz),
		.divisor (cct_pkg::US_PER_MS),
		.q_bit   (q_ms),
		.rem     (rem_us)
	);

	cct_div_cell u_div_ms (
		.clk     (clk),
		.ctrl    (div_ctrl),
		.bit_in  (q_ms),
		.divisor (cct_pkg::US_PER_MS),
		.q_bit   (q_s),
		.rem     (rem_ms)
	);

	// Sequencer: idle, one bit per cycle through the dividers, then hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Dividend and quotient shift registers; a zero clock divides by one.
	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_q <= ext;
			div_q      <= (clock_mhz_q == '0) ? cct_pkg::MHZ_W'(1) : clock_mhz_q;
			delta_q    <= delta;
			wrapped_q  <= wrap_hit;
		end else if (div_ctrl.step) begin
			dividend_q <= {dividend_q[EXT_W-2:0], 1'b0};
			total_q    <= {total_q[EXT_W-2:0], q_mhz};
			secs_q     <= {secs_q[EXT_W-2:0], q_s};
		end
	end

	// Output register holds the finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			seconds_q     <= secs_q[cct_pkg::SECONDS_W-1:0];
			ms_q          <= rem_ms;
			us_q          <= rem_us;
			total_out_q   <= cct_pkg::TOTAL_W'(total_q);
			delta_out_q   <= delta_q;
			wrapped_out_q <= wrapped_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign seconds            = seconds_q;
	assign milliseconds       = ms_q;
	assign microseconds       = us_q;
	assign total_microseconds = total_out_q;
	assign delta_cycles       = delta_out_q;
	assign wrapped            = wrapped_out_q;

	// The remainder of the first cell is the sub-microsecond part and is not reported.
	logic unused_rem;
	assign unused_rem = ^rem_mhz;

endmodule

// ===== bench/cycle_count_time_split_test.sv =====
module cycle_count_time_split_test;

	import cct_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int PHASES       = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 80;

	// One result request, laid out field by field as the block presents it.
	typedef struct packed {
		logic [SECONDS_W-1:0] seconds;
		logic [SUBSEC_W-1:0]  milliseconds;
		logic [SUBSEC_W-1:0]  microseconds;
		logic [TOTAL_W-1:0]   total_us;
		logic [DELTA_W-1:0]   delta;
		logic                 wrapped;
	} split_t;

	// One row of the directed table: clock setting, sample and an optional typed answer.
	typedef struct {
		logic [MHZ_W-1:0]    clock;
		logic [SAMPLE_W-1:0] sample;
		bit                  typed;
		split_t              want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [MHZ_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [SAMPLE_W-1:0]   counter_sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SECONDS_W-1:0]  seconds;
	logic [SUBSEC_W-1:0]   milliseconds;
	logic [SUBSEC_W-1:0]   microseconds;
	logic [TOTAL_W-1:0]    total_microseconds;
	logic [DELTA_W-1:0]    delta_cycles;
	logic                  wrapped;

	// Typed answer travelling alongside the sample request that it belongs to.
	bit                    typed_active = 1'b0;
	split_t                typed_want = '0;

	// Predictor state and the clock setting that the block should hold.
	logic [SAMPLE_W-1:0]   last_sample = '0;
	logic [WRAP_BITS-1:0]  wrap_total = '0;
	logic [MHZ_W-1:0]      clock_setting = MHZ_RESET;
	logic [MHZ_W-1:0]      written_clock = MHZ_RESET;

	split_t                pending_splits[$];
	row_t                  directed_rows[$];
	int                    mismatches = 0;
	int                    idle_cycles = 0;
	bit                    steady_in = 1'b0;
	bit                    steady_out = 1'b0;

	cycle_count_time_split DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.counter_sample     (counter_sample),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.seconds            (seconds),
		.milliseconds       (milliseconds),
		.microseconds       (microseconds),
		.total_microseconds (total_microseconds),
		.delta_cycles       (delta_cycles),
		.wrapped            (wrapped)
	);

	always #5 clk = ~clk;

	// Extends a sample by the wrap count and splits it into seconds, milliseconds and
	// microseconds at the current clock setting. Updates the wrap state as it goes.
	function automatic split_t timestamp_split(input logic [SAMPLE_W-1:0] sample);
		logic [63:0] ext;
		logic [63:0] mhz;
		logic [63:0] per_s;
		logic [63:0] per_ms;
		logic [63:0] secs;
		logic [63:0] rem_s;
		logic [63:0] ms;
		logic [63:0] rem_ms;
		logic [63:0] us;
		split_t      r;
		r.wrapped = (sample < last_sample);
		r.delta = sample - last_sample;
		// The wrap is counted before the extended count is formed.
		wrap_total = wrap_total + WRAP_BITS'(r.wrapped);
		last_sample = sample;
		// A zero clock setting behaves as 1 MHz so that no divisor is zero.
		mhz = (clock_setting == '0) ? 64'd1 : 64'(clock_setting);
		per_s = mhz * 64'd1000000;
		per_ms = mhz * 64'd1000;
		ext = {wrap_total, sample};
		secs = ext / per_s;
		rem_s = ext % per_s;
		ms = rem_s / per_ms;
		rem_ms = rem_s % per_ms;
		us = rem_ms / mhz;
		r.seconds = secs[SECONDS_W-1:0];
		r.milliseconds = ms[SUBSEC_W-1:0];
		r.microseconds = us[SUBSEC_W-1:0];
		r.total_us = secs * 64'd1000000 + ms * 64'd1000 + us;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch in %s: got 0x%0h, want 0x%0h", field, got, want);
		mismatches++;
	endtask

	task automatic add_row(input logic [MHZ_W-1:0] clock, input logic [SAMPLE_W-1:0] sample,
		input bit typed, input split_t want);
		row_t row;
		row.clock = clock;
		row.sample = sample;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Presents one sample request after a random pause and waits for it to be taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit typed,
		input split_t want);
		int pause;
		if ($urandom_range(0, 29) == 0) begin
			steady_in = !steady_in;
		end
		pause = steady_in ? 0 : $urandom_range(0, 7);
		if (pause > 0) begin
			in_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		in_valid <= 1'b1;
		counter_sample <= sample;
		typed_active <= typed;
		typed_want <= want;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Writes the clock register once every outstanding result has come back.
	task automatic change_clock(input logic [MHZ_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_splits.size() != 0) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		written_clock = value;
	endtask

	// Result side: stalls a random number of cycles before each result request.
	initial begin
		int stall;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				steady_out = !steady_out;
			end
			stall = steady_out ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Tracks register writes, predicts each accepted sample and checks each result.
	always @(posedge clk) begin
		split_t got;
		split_t want;
		split_t next;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				clock_setting = cfg_data;
			end
			if (out_valid && out_ready) begin
				got = '{seconds, milliseconds, microseconds, total_microseconds,
					delta_cycles, wrapped};
				if (pending_splits.size() == 0) begin
					flag_mismatch("unrequested result", total_microseconds, '0);
				end else begin
					want = pending_splits.pop_front();
					if (got.seconds !== want.seconds)
						flag_mismatch("seconds", 64'(got.seconds), 64'(want.seconds));
					if (got.milliseconds !== want.milliseconds)
						flag_mismatch("milliseconds", 64'(got.milliseconds),
							64'(want.milliseconds));
					if (got.microseconds !== want.microseconds)
						flag_mismatch("microseconds", 64'(got.microseconds),
							64'(want.microseconds));
					if (got.total_us !== want.total_us)
						flag_mismatch("total_microseconds", got.total_us, want.total_us);
					if (got.delta !== want.delta)
						flag_mismatch("delta_cycles", 64'(got.delta), 64'(want.delta));
					if (got.wrapped !== want.wrapped)
						flag_mismatch("wrapped", 64'(got.wrapped), 64'(want.wrapped));
				end
			end
			if (in_valid && in_ready) begin
				next = timestamp_split(counter_sample);
				pending_splits.push_back(typed_active ? typed_want : next);
			end
		end
	end

	// Watchdog: ends the run when no request of any kind moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus: directed table first, then random phases at several clock settings.
	initial begin
		logic [MHZ_W-1:0]    phase_clock[PHASES];
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] recent;
		int                  mag;

		// Reset goes low from unknown so that the asynchronous reset sees a falling edge.
		arst_n = 1'b0;

		// Straight after reset at 168 MHz: zero, one microsecond, one millisecond, no wrap on an equal sample.
		add_row(MHZ_RESET, 32'd0, 1'b1, '{45'd0, 10'd0, 10'd0, 64'd0, 32'd0, 1'b0});
		add_row(MHZ_RESET, 32'd168, 1'b1, '{45'd0, 10'd0, 10'd1, 64'd1, 32'd168, 1'b0});
		add_row(MHZ_RESET, 32'd168000, 1'b1,
			'{45'd0, 10'd1, 10'd0, 64'd1000, 32'd167832, 1'b0});
		add_row(MHZ_RESET, 32'd168000, 1'b1, '{45'd0, 10'd1, 10'd0, 64'd1000, 32'd0, 1'b0});
		add_row(MHZ_RESET, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(MHZ_RESET, 32'h0000_0000, 1'b0, '0);
		add_row(MHZ_RESET, 32'h0000_0001, 1'b0, '0);
		// Lowest clock with alternating bit patterns and repeated wraps.
		add_row(10'd1, 32'hFFFF_FFFF, 1'b0, '0);
		add_row(10'd1, 32'h8000_0000, 1'b0, '0);
		add_row(10'd1, 32'h7FFF_FFFF, 1'b0, '0);
		add_row(10'd1, 32'hAAAA_AAAA, 1'b0, '0);
		add_row(10'd1, 32'h5555_5555, 1'b0, '0);
		// A zero clock setting behaves as 1 MHz; samples either side of one second.
		add_row(10'd0, 32'd999_999, 1'b0, '0);
		add_row(10'd0, 32'd1_000_000, 1'b0, '0);
		// Top of the range and the values above it.
		add_row(10'd1000, 32'd999_999_999, 1'b0, '0);
		add_row(10'd1000, 32'd1_000_000_000, 1'b0, '0);
		add_row(10'd1023, 32'hFFFF_FFFE, 1'b0, '0);
		add_row(10'd1023, 32'h0000_0001, 1'b0, '0);
		add_row(10'd1001, 32'h1234_5678, 1'b0, '0);
		add_row(10'd1001, 32'hFEDC_BA98, 1'b0, '0);
		add_row(MHZ_RESET, 32'h0000_0000, 1'b0, '0);

		phase_clock[0] = 10'd1;
		phase_clock[1] = 10'd1000;
		phase_clock[2] = 10'd1023;
		phase_clock[3] = 10'd0;
		phase_clock[4] = MHZ_W'($urandom_range(1, 1000));
		phase_clock[5] = MHZ_RESET;
		phase_clock[6] = MHZ_W'($urandom_range(0, 1023));
		phase_clock[7] = MHZ_W'($urandom_range(1, 1000));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].clock != written_clock) begin
				change_clock(directed_rows[i].clock);
			end
			send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
		end

		// Mostly a counter moving forwards at random rates, wrapping on its own, with
		// forced wraps, repeats, values near the top and plain noise mixed in.
		recent = 32'h0000_0000;
		for (int p = 0; p < PHASES; p++) begin
			change_clock(phase_clock[p]);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				case ($urandom_range(0, 9))
					0: sample = 32'hFFFF_FFFF - $urandom_range(0, 255);
					1: sample = $urandom_range(0, 1023);
					2: sample = recent;
					3: sample = $urandom;
					default: begin
						mag = $urandom_range(0, 31);
						sample = recent + ($urandom & ((32'd1 << mag) - 32'd1));
					end
				endcase
				send_sample(sample, 1'b0, '0);
				recent = sample;
			end
		end

		// Let the last results drain, then allow for anything stray.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_splits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cct_pkg.sv
rtl/core/cct_div_cell.sv
rtl/core/cct_wrap_track.sv
rtl/core/cycle_count_time_split.sv
bench/cycle_count_time_split_test.sv
